FILE: design/rbsd_pkg.sv
// shared types and constants for the bulk string deframer
`timescale 1ns / 1ps

package rbsd_pkg;

	localparam int unsigned LenWidth = 31;

	// phase codes
	localparam logic [1:0] PH_LENGTH = 2'd0;
	localparam logic [1:0] PH_DATA   = 2'd1;
	localparam logic [1:0] PH_CR     = 2'd2;
	localparam logic [1:0] PH_LF     = 2'd3;

	// event codes
	localparam logic [1:0] EV_MORE   = 2'd0;
	localparam logic [1:0] EV_DATA   = 2'd1;
	localparam logic [1:0] EV_DONE   = 2'd2;
	localparam logic [1:0] EV_CANCEL = 2'd3;

	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	typedef logic [LenWidth-1:0] len_t;

	typedef struct packed {
		logic [1:0] phase;
		len_t       length_accum;
		len_t       bytes_left;
		logic       minus_seen;
		logic       digit_seen;
		logic       line_bad;
		logic       cr_pending;
	} state_t;

	typedef struct packed {
		logic [1:0] event_res;
		logic [7:0] payload_byte;
		logic       payload_last;
	} result_t;

endpackage

FILE: design/rbsd_step.sv
// per-byte next-state and result logic of the bulk string deframer
`timescale 1ns / 1ps

module rbsd_step
	import rbsd_pkg::*;
(
	input  state_t     cur,
	input  logic [7:0] in_byte,
	input  len_t       length_limit,
	output state_t     nxt,
	output result_t    res
);

	logic [LenWidth+3:0] accum_x10;
	logic                is_digit;
	logic                line_fail;

	assign is_digit  = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
	assign accum_x10 = {1'b0, cur.length_accum, 3'b000}
		+ {3'b000, cur.length_accum, 1'b0}
		+ {{LenWidth{1'b0}}, in_byte[3:0]};
	assign line_fail = cur.line_bad || !cur.digit_seen
		|| (cur.minus_seen && (cur.length_accum != '0));

	always_comb begin
		nxt = cur;
		res.event_res = EV_MORE;
		res.payload_byte = 8'h00;
		res.payload_last = 1'b0;
		unique case (cur.phase)
			PH_LENGTH: begin
				if (cur.cr_pending && (in_byte == CHAR_LF)) begin
					nxt.length_accum = '0;
					nxt.minus_seen = 1'b0;
					nxt.digit_seen = 1'b0;
					nxt.line_bad = 1'b0;
					nxt.cr_pending = 1'b0;
					if (line_fail) begin
						res.event_res = EV_CANCEL;
						nxt.phase = PH_LENGTH;
					end else begin
						nxt.bytes_left = cur.length_accum;
						nxt.phase = (cur.length_accum == '0) ? PH_CR : PH_DATA;
					end
				end else begin
					// stray cr makes the line malformed
					if (cur.cr_pending) begin
						nxt.line_bad = 1'b1;
						nxt.cr_pending = 1'b0;
					end
					if (in_byte == CHAR_CR) begin
						nxt.cr_pending = 1'b1;
					end else if (in_byte == CHAR_LF) begin
						nxt.line_bad = 1'b1;
					end else if (in_byte == CHAR_MINUS) begin
						if (cur.minus_seen || cur.digit_seen)
							nxt.line_bad = 1'b1;
						nxt.minus_seen = 1'b1;
					end else if (is_digit) begin
						nxt.digit_seen = 1'b1;
						if (!nxt.line_bad) begin
							if (accum_x10 > {4'b0000, length_limit})
								nxt.line_bad = 1'b1;
							else
								nxt.length_accum = accum_x10[LenWidth-1:0];
						end
					end else begin
						nxt.line_bad = 1'b1;
					end
				end
			end
			PH_DATA: begin
				res.event_res = EV_DATA;
				res.payload_byte = in_byte;
				if (cur.bytes_left <= len_t'(1)) begin
					res.payload_last = 1'b1;
					nxt.bytes_left = '0;
					nxt.phase = PH_CR;
				end else begin
					nxt.bytes_left = cur.bytes_left - len_t'(1);
				end
			end
			PH_CR: begin
				if (in_byte == CHAR_CR) begin
					nxt.phase = PH_LF;
				end else begin
					res.event_res = EV_CANCEL;
					nxt.phase = PH_LENGTH;
				end
			end
			PH_LF: begin
				res.event_res = (in_byte == CHAR_LF) ? EV_DONE : EV_CANCEL;
				nxt.phase = PH_LENGTH;
			end
			default: begin
				nxt.phase = PH_LENGTH;
			end
		endcase
	end

endmodule

FILE: design/resp_bulk_string_deframer_unit.sv
// top level of the bulk string deframer
// Usage:
// - input channel: in_valid / in_stall / in_byte, one raw byte per transfer,
//   starting with the first byte after the type marker of a bulk string
// - output channel: out_valid / out_stall with event_res, payload_byte and
//   payload_last; every input byte yields exactly one output transfer
// - events: more (byte consumed), data (payload byte), done, cancel
// - length_limit is written with length_limit_wr while the block is idle
// - the result is registered: the input register, then the step logic into the
//   result register
// - throughput: one byte per cycle while out_stall is low; the parser state updates
//   once per byte in the step logic between the two registers
// - when out_stall is high with a valid result, the result register holds and the
//   input register fills; in_stall rises once the input register is full and cannot move
// - reset clears both stages, the parser state (back to length reading) and
//   restores length_limit to its largest value
`timescale 1ns / 1ps

module resp_bulk_string_deframer_unit
	import rbsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       length_limit_wr,
	input  len_t       length_limit,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] event_res,
	output logic [7:0] payload_byte,
	output logic       payload_last
);

	len_t       limit_q;
	state_t     state_q;
	state_t     state_nxt;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	result_t    res_s2;
	result_t    res_nxt;
	logic       advance;
	logic       step;

	assign advance  = !valid_s2 || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	rbsd_step u_step (
		.cur          (state_q),
		.in_byte      (byte_s1),
		.length_limit (limit_q),
		.nxt          (state_nxt),
		.res          (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '1;
		end else if (length_limit_wr) begin
			limit_q <= length_limit;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			byte_s1 <= in_byte;
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (step) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			res_s2 <= res_nxt;
	end

	assign out_valid    = valid_s2;
	assign event_res    = res_s2.event_res;
	assign payload_byte = res_s2.payload_byte;
	assign payload_last = res_s2.payload_last;

	// data phase always has bytes left to pass
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_DATA) |-> (state_q.bytes_left != '0))
		else $error("data phase with no bytes left");

	// parser state only moves when a byte steps through
	assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(state_q))
		else $error("parser state changed without a byte");

	// last flag only on payload bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && payload_last) |-> (event_res == EV_DATA))
		else $error("last flag outside payload byte");

	// non-payload results carry a zero byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (event_res != EV_DATA)) |-> (payload_byte == 8'h00))
		else $error("payload byte not zero");

	// an empty input register never stalls the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("stall with empty input register");

endmodule

FILE: tb/sv/testbench.sv
// self-checking testbench for the bulk string deframer: predicted events vs. rtl output
`timescale 1ns / 1ps

module testbench
	import rbsd_pkg::*;
();

	class deframe_scoreboard;
		logic [1:0] phase;
		len_t       accum;
		len_t       left;
		len_t       limit;
		bit         minus_seen, digit_seen, line_bad, cr_pending;
		result_t    pending_events[$];
		int         inputs, checked, mismatches, n_data, n_done, n_cancel;

		function new();
			phase = PH_LENGTH;
			accum = '0;
			left = '0;
			limit = '1;
			minus_seen = 0;
			digit_seen = 0;
			line_bad = 0;
			cr_pending = 0;
		endfunction

		function void set_limit(len_t v);
			limit = v;
		endfunction

		function int pending();
			return pending_events.size();
		endfunction

		function bit line_clean();
			return phase == PH_LENGTH && accum == 0 && !minus_seen && !digit_seen
				&& !line_bad && !cr_pending;
		endfunction

		// an lf now would open a payload too long for the run
		function bit big_line_pending();
			return phase == PH_LENGTH && cr_pending && !line_bad && digit_seen
				&& !minus_seen && accum > 64;
		endfunction

		// advance the parser by one transfer and queue the event it causes
		function void take_byte(logic [7:0] b);
			result_t     r;
			logic [63:0] v;
			bit          bad;
			r = '0;
			r.event_res = EV_MORE;
			case (phase)
				PH_LENGTH: begin
					if (cr_pending && b == CHAR_LF) begin
						bad = line_bad || !digit_seen || (minus_seen && accum != 0);
						if (bad) begin
							r.event_res = EV_CANCEL;
						end else begin
							left = accum;
							phase = (accum == 0) ? PH_CR : PH_DATA;
						end
						accum = '0;
						minus_seen = 0;
						digit_seen = 0;
						line_bad = 0;
						cr_pending = 0;
					end else begin
						if (cr_pending) begin
							line_bad = 1;
							cr_pending = 0;
						end
						if (b == CHAR_CR) begin
							cr_pending = 1;
						end else if (b == CHAR_LF) begin
							line_bad = 1;
						end else if (b == CHAR_MINUS) begin
							if (minus_seen || digit_seen)
								line_bad = 1;
							minus_seen = 1;
						end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
							digit_seen = 1;
							if (!line_bad) begin
								v = {33'b0, accum} * 64'd10 + {56'b0, b - CHAR_ZERO};
								if (v > {33'b0, limit})
									line_bad = 1;
								else
									accum = v[LenWidth-1:0];
							end
						end else begin
							line_bad = 1;
						end
					end
				end
				PH_DATA: begin
					r.event_res = EV_DATA;
					r.payload_byte = b;
					if (left <= 1) begin
						r.payload_last = 1'b1;
						left = '0;
						phase = PH_CR;
					end else begin
						left = left - 1'b1;
					end
				end
				PH_CR: begin
					if (b == CHAR_CR) begin
						phase = PH_LF;
					end else begin
						r.event_res = EV_CANCEL;
						phase = PH_LENGTH;
					end
				end
				default: begin
					r.event_res = (b == CHAR_LF) ? EV_DONE : EV_CANCEL;
					phase = PH_LENGTH;
				end
			endcase
			pending_events = {pending_events, r};
			inputs++;
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			if (mismatches <= 20)
				$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		task match_event(logic [1:0] ev, logic [7:0] pb, logic last);
			result_t want;
			if (pending_events.size() == 0) begin
				report_mismatch($sformatf("unexpected transfer, event %0d", ev));
				return;
			end
			want = pending_events.pop_front();
			checked++;
			if (ev !== want.event_res)
				report_mismatch($sformatf("result %0d event %0d, want %0d",
					checked, ev, want.event_res));
			if (pb !== want.payload_byte)
				report_mismatch($sformatf("result %0d payload_byte %0h, want %0h",
					checked, pb, want.payload_byte));
			if (last !== want.payload_last)
				report_mismatch($sformatf("result %0d payload_last %0b, want %0b",
					checked, last, want.payload_last));
			case (want.event_res)
				EV_DATA:   n_data++;
				EV_DONE:   n_done++;
				EV_CANCEL: n_cancel++;
				default:   ;
			endcase
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       length_limit_wr;
	len_t       length_limit;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       out_valid;
	logic       out_stall;
	logic [1:0] event_res;
	logic [7:0] payload_byte;
	logic       payload_last;

	deframe_scoreboard board = new();
	int send_idle;
	int recv_idle;

	resp_bulk_string_deframer_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.length_limit_wr(length_limit_wr),
		.length_limit   (length_limit),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.event_res      (event_res),
		.payload_byte   (payload_byte),
		.payload_last   (payload_last)
	);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.match_event(event_res, payload_byte, payload_last);
	end

	// called and returns at a falling edge
	task automatic send_byte(logic [7:0] b);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.take_byte(b);
		@(negedge clk);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_crlf();
		send_byte(CHAR_CR);
		send_byte(CHAR_LF);
	endtask

	task automatic send_number(longint unsigned n);
		logic [7:0] digits[$];
		do begin
			digits.push_front(CHAR_ZERO + 8'(n % 10));
			n = n / 10;
		end while (n != 0);
		foreach (digits[i])
			send_byte(digits[i]);
	endtask

	function automatic logic [7:0] other_than(logic [7:0] x);
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == x)
			b = ~x;
		return b;
	endfunction

	function automatic logic [7:0] junk_char();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_CR || b == CHAR_LF
			|| b == CHAR_MINUS);
		return b;
	endfunction

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_limit(len_t v);
		wait_drained();
		length_limit_wr <= 1'b1;
		length_limit <= v;
		@(negedge clk);
		length_limit_wr <= 1'b0;
		board.set_limit(v);
	endtask

	// length line, payload and closing; spoil breaks the closing cr lf
	task automatic send_string(bit spoil);
		int n;
		n = ($urandom_range(99) < 80) ? $urandom_range(0, 8) : $urandom_range(9, 64);
		if (n > board.limit)
			n = board.limit;
		if (n == 0 && $urandom_range(3) == 0)
			send_byte(CHAR_MINUS);
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 2)) send_byte(CHAR_ZERO);
		send_number(n);
		send_crlf();
		repeat (n) send_byte(8'($urandom_range(0, 255)));
		if (!spoil) begin
			send_crlf();
		end else if ($urandom_range(1)) begin
			send_byte(other_than(CHAR_CR));
		end else begin
			send_byte(CHAR_CR);
			send_byte(other_than(CHAR_LF));
		end
	endtask

	// length lines that must cancel at their cr lf
	task automatic send_bad_length();
		case ($urandom_range(0, 6))
			0: begin
				send_number($urandom_range(0, 99));
				send_byte(junk_char());
				send_number($urandom_range(0, 9));
			end
			1: begin
				send_number($urandom_range(0, 99));
				send_byte(CHAR_CR);
				if ($urandom_range(1))
					send_byte(CHAR_CR);
				send_number($urandom_range(0, 9));
			end
			2: begin
				send_number($urandom_range(0, 99));
				send_byte(CHAR_LF);
			end
			3: begin
				if ($urandom_range(1)) begin
					send_byte(CHAR_MINUS);
					send_byte(CHAR_MINUS);
					send_number($urandom_range(0, 9));
				end else begin
					send_number($urandom_range(0, 99));
					send_byte(CHAR_MINUS);
				end
			end
			4: begin
				send_byte(CHAR_MINUS);
				if ($urandom_range(1))
					send_byte(CHAR_ZERO);
				send_number($urandom_range(1, 999));
			end
			5: begin
				send_number({33'b0, board.limit} + 64'd1 + 64'($urandom_range(0, 999)));
				if ($urandom_range(1))
					send_number($urandom_range(0, 9));
			end
			default: begin
				if ($urandom_range(1))
					send_byte(CHAR_MINUS);
			end
		endcase
		send_crlf();
	endtask

	task automatic send_noise();
		logic [7:0] b;
		repeat ($urandom_range(1, 12)) begin
			b = 8'($urandom_range(0, 255));
			if (b == CHAR_LF && board.big_line_pending())
				b = CHAR_CR;
			send_byte(b);
		end
	endtask

	// bring the parser back to a clean length line
	task automatic resync();
		while (!board.line_clean()) begin
			case (board.phase)
				PH_LENGTH: begin
					send_text("x");
					send_crlf();
				end
				PH_DATA: send_byte(8'($urandom_range(0, 255)));
				PH_CR:   send_byte(CHAR_CR);
				default: send_byte(CHAR_LF);
			endcase
		end
	endtask

	task automatic send_random_frame();
		int r;
		r = $urandom_range(99);
		if (r < 62)
			send_string(1'b0);
		else if (r < 80)
			send_bad_length();
		else if (r < 90)
			send_string(1'b1);
		else
			send_noise();
		resync();
	endtask

	initial begin
		int   start;
		len_t lim;
		clk = 1'b0;
		arst_n = 1'b0;
		length_limit_wr = 1'b0;
		length_limit = '0;
		in_valid = 1'b0;
		in_byte = '0;
		out_stall = 1'b0;
		send_idle = 17;
		recv_idle = 72;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: payload extremes, minus zero with bad lf, stray cr/lf with
		// misplaced minus, empty line, negative length, zero length with bad cr
		send_text("2");
		send_crlf();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_crlf();
		send_text("-0");
		send_crlf();
		send_byte(CHAR_CR);
		send_text("X");
		send_text("1");
		send_byte(CHAR_CR);
		send_text("-");
		send_byte(CHAR_LF);
		send_crlf();
		send_crlf();
		send_text("-1");
		send_crlf();
		send_text("0");
		send_crlf();
		send_text("Z");

		for (int seg = 0; seg < 6; seg++) begin
			case (seg / 2)
				0: begin
					send_idle = 17;
					recv_idle = 72;
				end
				1: begin
					send_idle = 72;
					recv_idle = 17;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			case (seg)
				0, 3:    lim = '1;
				1:       lim = '0;
				2:       lim = len_t'($urandom_range(1, 40));
				4:       lim = len_t'($urandom_range(0, 9));
				default: lim = len_t'($urandom);
			endcase
			write_limit(lim);
			start = board.inputs;
			while (board.inputs - start < 325)
				send_random_frame();
		end

		wait_drained();
		repeat (10) @(negedge clk);
		$display("sent %0d bytes, checked %0d results: %0d payload, %0d done, %0d cancel",
			board.inputs, board.checked, board.n_data, board.n_done, board.n_cancel);
		$display("length limits zero, small, random and full; stalls on each side and none");
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("timeout with %0d results outstanding", board.pending());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
